/* hw/rtl/ascii_integer_parser_assert.svh */
// Assertion macros used by the checker of the integer parser.
`ifndef ASCII_INTEGER_PARSER_ASSERT_SVH
`define ASCII_INTEGER_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define AIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define AIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/aip_pkg.sv */
`timescale 1ns / 1ps

package aip_pkg;

  localparam int unsigned ValueW = 64;

  typedef enum logic [5:0] {
    PH_WS   = 6'b000001,
    PH_SIGN = 6'b000010,
    PH_ZERO = 6'b000100,
    PH_DEC  = 6'b001000,
    PH_HEX  = 6'b010000,
    PH_STOP = 6'b100000
  } aip_phase_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  // Finished string: magnitude and sign, handed from the step stage to the finish stage.
  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] mag;
  } aip_fin_t;

endpackage

/* hw/rtl/aip_step.sv */
`timescale 1ns / 1ps

module aip_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          char_byte_i,
  input  logic                is_last_i,
  output logic                fin_valid_o,
  input  logic                fin_ready_i,
  output aip_pkg::aip_fin_t   fin_o
);

  logic                       s0_valid_q;
  logic [7:0]                 char_q;
  logic                       last_q;
  aip_pkg::aip_phase_e        phase_q, phase_d;
  logic                       neg_q, neg_d;
  logic [aip_pkg::ValueW-1:0] acc_q, acc_d;
  logic                       end_str;
  logic                       consume;
  logic                       is_dec;
  logic                       is_hex;
  logic                       is_alpha;
  logic [3:0]                 hex_val;
  logic [aip_pkg::ValueW-1:0] dec_acc;

  assign end_str     = (char_q == aip_pkg::CH_NUL) || last_q;
  assign consume     = s0_valid_q && (!end_str || fin_ready_i);
  assign in_ready_o  = !s0_valid_q || consume;
  assign fin_valid_o = s0_valid_q && end_str;
  assign fin_o       = '{neg: neg_d, mag: acc_d};

  always_comb begin
    is_dec   = char_q inside {[aip_pkg::CH_DIG0 : aip_pkg::CH_DIG9]};
    is_alpha = char_q inside {[aip_pkg::CH_UA : aip_pkg::CH_UF],
                              [aip_pkg::CH_LA : aip_pkg::CH_LF]};
    is_hex   = is_dec || is_alpha;
    hex_val  = is_alpha ? (char_q[3:0] + 4'd9) : char_q[3:0];
    // acc*10 as acc*8 + acc*2
    dec_acc  = (acc_q << 3) + (acc_q << 1) + aip_pkg::ValueW'(char_q[3:0]);
  end

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    if (char_q != aip_pkg::CH_NUL) begin
      case (phase_q)
        aip_pkg::PH_WS: begin
          if (char_q == aip_pkg::CH_SPACE || char_q == aip_pkg::CH_TAB) begin
            phase_d = aip_pkg::PH_WS;
          end else if (char_q == aip_pkg::CH_MINUS || char_q == aip_pkg::CH_PLUS) begin
            neg_d   = (char_q == aip_pkg::CH_MINUS);
            phase_d = aip_pkg::PH_SIGN;
          end else if (char_q == aip_pkg::CH_DIG0) begin
            phase_d = aip_pkg::PH_ZERO;
          end else if (is_dec) begin
            acc_d   = aip_pkg::ValueW'(char_q[3:0]);
            phase_d = aip_pkg::PH_DEC;
          end else begin
            phase_d = aip_pkg::PH_STOP;
          end
        end
        aip_pkg::PH_SIGN: begin
          if (char_q == aip_pkg::CH_DIG0) begin
            phase_d = aip_pkg::PH_ZERO;
          end else if (is_dec) begin
            acc_d   = aip_pkg::ValueW'(char_q[3:0]);
            phase_d = aip_pkg::PH_DEC;
          end else begin
            phase_d = aip_pkg::PH_STOP;
          end
        end
        aip_pkg::PH_ZERO: begin
          if (char_q == aip_pkg::CH_LX || char_q == aip_pkg::CH_UX) begin
            phase_d = aip_pkg::PH_HEX;
          end else if (is_dec) begin
            acc_d   = aip_pkg::ValueW'(char_q[3:0]);
            phase_d = aip_pkg::PH_DEC;
          end else begin
            phase_d = aip_pkg::PH_STOP;
          end
        end
        aip_pkg::PH_DEC: begin
          if (is_dec) begin
            acc_d = dec_acc;
          end else begin
            phase_d = aip_pkg::PH_STOP;
          end
        end
        aip_pkg::PH_HEX: begin
          if (is_hex) begin
            acc_d = {acc_q[aip_pkg::ValueW-5:0], hex_val};
          end else begin
            phase_d = aip_pkg::PH_STOP;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_byte_i;
      last_q <= is_last_i;
    end
  end

  // parse state; a finished string puts it back to its idle values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= aip_pkg::PH_WS;
      neg_q   <= 1'b0;
      acc_q   <= '0;
    end else if (consume) begin
      if (end_str) begin
        phase_q <= aip_pkg::PH_WS;
        neg_q   <= 1'b0;
        acc_q   <= '0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
      end
    end
  end

endmodule

/* hw/rtl/aip_finish.sv */
`timescale 1ns / 1ps

module aip_finish (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fin_valid_i,
  output logic                              fin_ready_o,
  input  aip_pkg::aip_fin_t                 fin_i,
  input  logic                              mode32_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [aip_pkg::ValueW-1:0] parsed_value_o
);

  logic                       s1_valid_q;
  aip_pkg::aip_fin_t          s1_q;
  logic                       out_valid_q;
  logic [aip_pkg::ValueW-1:0] out_q;
  logic                       s2_ready;
  logic [aip_pkg::ValueW-1:0] signed_val;
  logic [aip_pkg::ValueW-1:0] wrap_val;

  assign s2_ready       = !out_valid_q || out_ready_i;
  assign fin_ready_o    = !s1_valid_q || s2_ready;
  assign out_valid_o    = out_valid_q;
  assign parsed_value_o = out_q;

  always_comb begin
    signed_val = s1_q.neg ? ('0 - s1_q.mag) : s1_q.mag;
    wrap_val   = mode32_i ? {{(aip_pkg::ValueW-32){signed_val[31]}}, signed_val[31:0]}
                          : signed_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_ready_o) begin
        s1_valid_q <= fin_valid_i;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_valid_i && fin_ready_o) begin
      s1_q <= fin_i;
    end
    if (s1_valid_q && s2_ready) begin
      out_q <= wrap_val;
    end
  end

endmodule

/* hw/rtl/ascii_integer_parser.sv */
`timescale 1ns / 1ps
// ASCII integer parser: decimal or 0x-prefixed hex text to a signed 64-bit value.
// Input channel (in_valid_i/in_ready_o): one character per beat on char_byte_i,
// is_last_i marks the final character. A NUL byte also ends the string and is
// not parsed as a character. Leading spaces/tabs and one sign are taken; the
// first non-digit stops accumulation and later bytes up to the end are dropped.
// Output channel (out_valid_o/out_ready_i): one beat per string on parsed_value_o.
// Config channel (cfg_valid_i/cfg_ready_o, always ready): cfg_data_i = 1 wraps
// results to 32 bits and sign-extends them. Write it only while no string is open.
// Throughput: one character per cycle while in_ready_o is high, set by the
// shift-add step on the accumulator, which closes its loop combinationally.
// Result path: the beat that ends the string passes the input register and the
// step stage, then the finish-stage register and the negate/wrap output register.
// A stalled receiver fills the output register and then one pending-result
// register; characters that do not end a string keep flowing until an ending
// beat has no room, at which point in_ready_o drops.
// Reset: parse state goes idle, pipeline empties, 64-bit mode selected.
module ascii_integer_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        char_byte_i,
  input  logic                              is_last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [aip_pkg::ValueW-1:0] parsed_value_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_data_i
);

  logic              mode32_q;
  logic              fin_valid;
  logic              fin_ready;
  aip_pkg::aip_fin_t fin;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode32_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode32_q <= cfg_data_i;
    end
  end

  aip_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_byte_i (char_byte_i),
    .is_last_i   (is_last_i),
    .fin_valid_o (fin_valid),
    .fin_ready_i (fin_ready),
    .fin_o       (fin)
  );

  aip_finish u_finish (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fin_valid_i    (fin_valid),
    .fin_ready_o    (fin_ready),
    .fin_i          (fin),
    .mode32_i       (mode32_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .parsed_value_o (parsed_value_o)
  );

endmodule

/* hw/rtl/aip_checker.sv */
`timescale 1ns / 1ps
`include "ascii_integer_parser_assert.svh"

module aip_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [aip_pkg::ValueW-1:0] parsed_value_o,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic                              cfg_data_i
);

  logic mode32_q;

  // shadow of the width mode, taken from config beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode32_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode32_q <= cfg_data_i;
    end
  end

  `AIP_ASSERT_NEXT(a_out_valid_holds, out_valid_o && !out_ready_i, out_valid_o,
                   "result beat dropped while stalled")
  `AIP_ASSERT_NEXT(a_out_data_holds, out_valid_o && !out_ready_i, $stable(parsed_value_o),
                   "result changed while stalled")
  `AIP_ASSERT_NOW(a_mode32_sign_ext, out_valid_o && mode32_q,
                  parsed_value_o[63:32] == {32{parsed_value_o[31]}},
                  "32-bit result not sign-extended")
  `AIP_ASSERT_NOW(a_no_bubble, !out_valid_o || out_ready_i, in_ready_o,
                  "input stalled although output side is free")

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .parsed_value_o (parsed_value_o),
  .cfg_valid_i    (cfg_valid_i),
  .cfg_ready_o    (cfg_ready_o),
  .cfg_data_i     (cfg_data_i)
);

/* bench/ascii_integer_parser_tb.sv */
`timescale 1ns / 1ps

module ascii_integer_parser_tb;

  localparam int unsigned RandomPerPhase = 320;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  // how a generated string is terminated
  typedef enum int {
    END_MARK,
    END_NUL,
    END_NUL_MARK
  } str_end_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        char_byte = aip_pkg::CH_NUL;
  logic              is_last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [63:0] parsed_value;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data = 1'b0;

  char_beat_t         char_q[$];
  logic [7:0]         text_buf[$];
  logic signed [63:0] expected_values[$];
  logic signed [63:0] want;
  char_beat_t         beat;

  // parser state mirrored by the testbench
  aip_pkg::aip_phase_e ph = aip_pkg::PH_WS;
  logic                neg_seen = 1'b0;
  logic [63:0]         acc = '0;
  logic                wrap32 = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_on = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  ascii_integer_parser uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .char_byte_i    (char_byte),
    .is_last_i      (is_last),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .parsed_value_o (parsed_value),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  task automatic parse_char(input logic [7:0] c, input logic last);
    logic [63:0] v;
    logic        dec;
    logic        alpha;
    dec = (c >= aip_pkg::CH_DIG0) && (c <= aip_pkg::CH_DIG9);
    alpha = (c >= aip_pkg::CH_LA && c <= aip_pkg::CH_LF) ||
            (c >= aip_pkg::CH_UA && c <= aip_pkg::CH_UF);
    if (c != aip_pkg::CH_NUL) begin
      case (ph)
        aip_pkg::PH_WS: begin
          if (c == aip_pkg::CH_MINUS || c == aip_pkg::CH_PLUS) begin
            neg_seen = (c == aip_pkg::CH_MINUS);
            ph = aip_pkg::PH_SIGN;
          end else if (c == aip_pkg::CH_DIG0) begin
            ph = aip_pkg::PH_ZERO;
          end else if (dec) begin
            acc = 64'(c - aip_pkg::CH_DIG0);
            ph = aip_pkg::PH_DEC;
          end else if (c != aip_pkg::CH_SPACE && c != aip_pkg::CH_TAB) begin
            ph = aip_pkg::PH_STOP;
          end
        end
        aip_pkg::PH_SIGN: begin
          if (c == aip_pkg::CH_DIG0) begin
            ph = aip_pkg::PH_ZERO;
          end else if (dec) begin
            acc = 64'(c - aip_pkg::CH_DIG0);
            ph = aip_pkg::PH_DEC;
          end else begin
            ph = aip_pkg::PH_STOP;
          end
        end
        aip_pkg::PH_ZERO: begin
          if (c == aip_pkg::CH_LX || c == aip_pkg::CH_UX) begin
            ph = aip_pkg::PH_HEX;
          end else if (dec) begin
            acc = 64'(c - aip_pkg::CH_DIG0);
            ph = aip_pkg::PH_DEC;
          end else begin
            ph = aip_pkg::PH_STOP;
          end
        end
        aip_pkg::PH_DEC: begin
          if (dec) acc = acc * 64'd10 + 64'(c - aip_pkg::CH_DIG0);
          else ph = aip_pkg::PH_STOP;
        end
        aip_pkg::PH_HEX: begin
          if (dec) begin
            acc = {acc[59:0], c[3:0]};
          end else if (alpha) begin
            // low nibble of a-f / A-F is 1..6
            acc = {acc[59:0], 4'(c[3:0] + 4'd9)};
          end else begin
            ph = aip_pkg::PH_STOP;
          end
        end
        default: ;
      endcase
    end
    if (c == aip_pkg::CH_NUL || last) begin
      v = neg_seen ? -acc : acc;
      if (wrap32) v = {{32{v[31]}}, v[31:0]};
      expected_values.push_back(v);
      ph = aip_pkg::PH_WS;
      neg_seen = 1'b0;
      acc = '0;
    end
  endtask

  // driver: one beat per handshake, prediction on every accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      char_byte <= aip_pkg::CH_NUL;
      is_last <= 1'b0;
      ph = aip_pkg::PH_WS;
      neg_seen = 1'b0;
      acc = '0;
    end else begin
      if (in_valid && in_ready) parse_char(char_byte, is_last);
      if (!in_valid || in_ready) begin
        if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          beat = char_q.pop_front();
          in_valid <= 1'b1;
          char_byte <= beat.ch;
          is_last <= beat.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off when requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_on && hold_cnt < HoldCycles) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (expected_values.size() == 0) begin
        $error("parsed_value: no value expected, got %0d", parsed_value);
        errors++;
      end else begin
        want = expected_values.pop_front();
        if (parsed_value !== want) begin
          $error("parsed_value: expected %0d, got %0d", want, parsed_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic put_char(input logic [7:0] c, input logic last);
    char_q.push_back('{ch: c, last: last});
    items_sent++;
  endtask

  task automatic emit_text(input str_end_e how);
    foreach (text_buf[i]) put_char(text_buf[i], how == END_MARK && i == text_buf.size() - 1);
    if (how != END_MARK || text_buf.size() == 0) put_char(aip_pkg::CH_NUL, how == END_NUL_MARK);
  endtask

  task automatic put_str(input string s, input str_end_e how);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    emit_text(how);
  endtask

  task automatic add_directed();
    // whitespace, minus, mixed-case hex and a 64-bit wrap
    put_str(" \t-0xfEdcba9876543210A", END_MARK);
    put_str("", END_NUL);
    // leading zero into decimal, stop, ignored byte, NUL flagged last
    put_str("+07z9", END_NUL_MARK);
    put_str("0Xg", END_MARK);
    put_str("-+", END_MARK);
    put_char(8'hFF, 1'b1);
  endtask

  task automatic add_random_string();
    int unsigned shape;
    int unsigned n;
    int unsigned r;
    int unsigned h;
    text_buf.delete();
    shape = $urandom_range(99);
    repeat ($urandom_range(2)) begin
      text_buf.push_back($urandom_range(1) ? aip_pkg::CH_SPACE : aip_pkg::CH_TAB);
    end
    case ($urandom_range(3))
      0: text_buf.push_back(aip_pkg::CH_MINUS);
      1: text_buf.push_back(aip_pkg::CH_PLUS);
      default: ;
    endcase
    n = ($urandom_range(7) == 0) ? $urandom_range(21, 8) : $urandom_range(6, 1);
    if (shape < 50) begin
      repeat (n) text_buf.push_back(8'(aip_pkg::CH_DIG0 + $urandom_range(9)));
    end else if (shape < 85) begin
      text_buf.push_back(aip_pkg::CH_DIG0);
      text_buf.push_back($urandom_range(1) ? aip_pkg::CH_LX : aip_pkg::CH_UX);
      if (n > 17) n = 17;
      repeat (n) begin
        h = $urandom_range(15);
        if (h < 10) begin
          text_buf.push_back(8'(aip_pkg::CH_DIG0 + h));
        end else begin
          text_buf.push_back(8'(($urandom_range(1) ? aip_pkg::CH_LA : aip_pkg::CH_UA)
                                + h - 10));
        end
      end
    end else begin
      repeat (n) text_buf.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(4) == 0) text_buf.push_back(8'($urandom_range(255)));
    r = $urandom_range(99);
    emit_text(r < 60 ? END_MARK : (r < 85 ? END_NUL : END_NUL_MARK));
  endtask

  task automatic wait_drained();
    while (char_q.size() != 0 || in_valid || expected_values.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    wrap32 = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic mode, input int unsigned send_pct,
                           input int unsigned recv_pct, input logic directed,
                           input logic hold);
    int unsigned start;
    write_mode(mode);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    hold_on = hold;
    if (directed) add_directed();
    start = items_sent;
    while (items_sent - start < RandomPerPhase) add_random_string();
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_phase(1'b0, 19, 77, 1'b1, 1'b0);
    run_phase(1'b1, 77, 19, 1'b1, 1'b0);
    // receiver holds off while beats keep coming, so the input backs up
    run_phase(1'b0, 0, 0, 1'b0, 1'b1);
    run_phase(1'b1, 0, 0, 1'b0, 1'b0);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
